/* design/rxd_pkg.sv */
package rxd_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned SHIFT_A    = 13;
  localparam int unsigned SHIFT_B    = 17;
  localparam int unsigned SHIFT_C    = 5;
  localparam int unsigned DIV_STEPS  = DATA_W;
  localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] RESEED_INTERVAL_RESET = COUNT_W'(50);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } rxd_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic publish;
  } rxd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip;
    logic div_last;
    logic out_free;
  } rxd_status_t;

endpackage

/* design/rxd_ctrl.sv */
module rxd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rxd_pkg::rxd_status_t status,
  output rxd_pkg::rxd_cmd_t    cmd
);

  rxd_pkg::rxd_state_t state_r;
  rxd_pkg::rxd_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rxd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rxd_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rxd_pkg::ST_DIV;
        end
      end
      rxd_pkg::ST_DIV: begin
        if (status.skip || status.div_last) begin
          state_nxt = rxd_pkg::ST_DONE;
        end
      end
      rxd_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_nxt = rxd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rxd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      rxd_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      rxd_pkg::ST_DIV: begin
        cmd.step = 1'b1;
      end
      rxd_pkg::ST_DONE: begin
        cmd.publish = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

/* design/rxd_dp.sv */
module rxd_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [rxd_pkg::COUNT_W-1:0]         cfg_wr_data,
  input  logic [rxd_pkg::DATA_W-1:0]          in_entropy_word,
  input  logic [rxd_pkg::DATA_W-1:0]          in_max_delay,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rxd_pkg::DATA_W-1:0]          out_delay_value,
  output logic                                out_reseeded,
  output logic                                out_zero_state_fault,
  input  rxd_pkg::rxd_cmd_t                   cmd,
  output rxd_pkg::rxd_status_t                status
);

  localparam int unsigned DW = rxd_pkg::DATA_W;
  localparam int unsigned CW = rxd_pkg::COUNT_W;
  localparam int unsigned SW = rxd_pkg::STEP_CNT_W;

  function automatic logic [DW-1:0] xorshift(input logic [DW-1:0] x);
    logic [DW-1:0] v;
    v = x;
    v = v ^ (v << rxd_pkg::SHIFT_A);
    v = v ^ (v >> rxd_pkg::SHIFT_B);
    v = v ^ (v << rxd_pkg::SHIFT_C);
    return v;
  endfunction

  logic [CW-1:0] interval_r;
  logic [DW-1:0] prng_state_r;
  logic [CW-1:0] request_count_r;

  logic [DW-1:0] dividend_r;
  logic [DW-1:0] divisor_r;
  logic [DW-1:0] rem_r;
  logic [SW-1:0] step_cnt_r;
  logic          skip_r;
  logic          fault_r;
  logic          reseed_r;

  logic          out_valid_r;
  logic [DW-1:0] out_delay_r;
  logic          out_reseeded_r;
  logic          out_fault_r;

  logic [CW-1:0] interval_eff;
  logic          reseed;
  logic [DW-1:0] seeded;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] request_count_nxt;
  logic          fault;
  logic [DW-1:0] advanced;
  logic [DW-1:0] prng_state_nxt;

  logic [DW:0]   rem_shift;
  logic          rem_ge;
  logic [DW-1:0] rem_nxt;

  // request bookkeeping, all settled in the accept cycle
  always_comb begin
    interval_eff      = (interval_r == '0) ? CW'(1) : interval_r;
    reseed            = (request_count_r == '0) || (prng_state_r == '0);
    seeded            = reseed ? in_entropy_word : prng_state_r;
    count_inc         = request_count_r + CW'(1);
    request_count_nxt = (count_inc >= interval_eff) ? '0 : count_inc;
    fault             = (seeded == '0);
    advanced          = xorshift(seeded);
    prng_state_nxt    = fault ? seeded : advanced;
  end

  // one restoring step of dividend_r mod divisor_r
  always_comb begin
    rem_shift = {rem_r, dividend_r[DW-1]};
    rem_ge    = (rem_shift >= {1'b0, divisor_r});
    rem_nxt   = rem_ge ? DW'(rem_shift - {1'b0, divisor_r}) : DW'(rem_shift);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r      <= rxd_pkg::RESEED_INTERVAL_RESET;
      prng_state_r    <= '0;
      request_count_r <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        interval_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        prng_state_r    <= prng_state_nxt;
        request_count_r <= request_count_nxt;
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dividend_r <= advanced;
      divisor_r  <= in_max_delay;
      rem_r      <= '0;
      step_cnt_r <= '0;
      skip_r     <= fault || (in_max_delay == '0);
      fault_r    <= fault;
      reseed_r   <= reseed;
    end else if (cmd.step && !skip_r) begin
      rem_r      <= rem_nxt;
      dividend_r <= {dividend_r[DW-2:0], 1'b0};
      step_cnt_r <= step_cnt_r + SW'(1);
    end
    if (cmd.publish) begin
      out_delay_r    <= skip_r ? '0 : rem_r;
      out_reseeded_r <= reseed_r;
      out_fault_r    <= fault_r;
    end
  end

  always_comb begin
    status.skip     = skip_r;
    status.div_last = (step_cnt_r == SW'(rxd_pkg::DIV_STEPS - 1));
    status.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid            = out_valid_r;
  assign out_delay_value      = out_delay_r;
  assign out_reseeded         = out_reseeded_r;
  assign out_zero_state_fault = out_fault_r;

`ifndef SYNTHESIS
  a_rem_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.publish && !skip_r) |-> (rem_r < divisor_r))
    else $error("remainder not below bound at publish");

  a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.publish && !skip_r) |-> (step_cnt_r == '0))
    else $error("result published before all division steps ran");

  a_fault_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fault_r) |-> (out_delay_r == '0 && out_reseeded_r))
    else $error("fault result must be a reseed with zero delay");

  a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> (out_valid_r && out_delay_r == $past(skip_r ? '0 : rem_r)))
    else $error("published result lost or altered");
`endif

endmodule

/* design/reseeded_xorshift_random_delay.sv */
// Random delay generator built on a reseeded xorshift32 state.
//
// Input channel (in_valid / in_stall): each transfer carries a fresh random
// word in_entropy_word and an exclusive bound in_max_delay. The state is
// reloaded from the random word when the request counter is at zero or the
// state itself is zero, then advanced once by xorshift32 (13, 17, 5).
// Output channel (out_valid / out_stall): one result per request, holding
// the advanced state modulo the bound, a reseed flag and a zero-state fault
// flag (delay 0). A bound of zero yields delay 0.
// Configuration: cfg_wr_en / cfg_wr_data set the reseed interval (reset 50);
// write only while no request is in flight. Zero acts as an interval of 1.
//
// The input transfer loads the request; the 32 steps of the one-bit-per-cycle
// restoring modulo unit then run, or are skipped for a zero bound or a fault;
// the result is then registered to out_valid once the output register frees.
// One request is in flight at a time: the next is taken only after publish.
// A finished result waits in the output register while out_stall is high,
// and the next request is taken and computed meanwhile; its result holds
// until the register frees. Synchronous reset clears the state, the counter
// and the output valid, and reloads the interval default.
module reseeded_xorshift_random_delay (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rxd_pkg::COUNT_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [rxd_pkg::DATA_W-1:0]  in_entropy_word,
  input  logic [rxd_pkg::DATA_W-1:0]  in_max_delay,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rxd_pkg::DATA_W-1:0]  out_delay_value,
  output logic                        out_reseeded,
  output logic                        out_zero_state_fault
);

  rxd_pkg::rxd_cmd_t    cmd;
  rxd_pkg::rxd_status_t status;

  rxd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  rxd_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_entropy_word      (in_entropy_word),
    .in_max_delay         (in_max_delay),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_delay_value      (out_delay_value),
    .out_reseeded         (out_reseeded),
    .out_zero_state_fault (out_zero_state_fault),
    .cmd                  (cmd),
    .status               (status)
  );

endmodule

/* tb/tb_reseeded_xorshift_random_delay.sv */
module tb_reseeded_xorshift_random_delay;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW = rxd_pkg::DATA_W;
  localparam int CW = rxd_pkg::COUNT_W;

  typedef struct packed {
    logic [DW-1:0] delay;
    logic          reseeded;
    logic          fault;
  } delay_result_t;

  typedef struct packed {
    logic          set_interval;
    logic [CW-1:0] interval;
    logic [DW-1:0] entropy;
    logic [DW-1:0] bound;
    logic          known;
    delay_result_t known_result;
  } request_row_t;

  localparam int NUM_ROWS   = 22;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_REQS = 178;
  localparam int TAIL_CYCLES = 40;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           cfg_wr_en = 1'b0;
  logic [CW-1:0]  cfg_wr_data = '0;
  logic           in_valid = 1'b0;
  logic           in_stall;
  logic [DW-1:0]  in_entropy_word = '0;
  logic [DW-1:0]  in_max_delay = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  logic [DW-1:0]  out_delay_value;
  logic           out_reseeded;
  logic           out_zero_state_fault;

  // shadow copy of the generator
  logic [DW-1:0] rng_state;
  logic [CW-1:0] rng_count;
  logic [CW-1:0] rng_interval;

  delay_result_t pending_delays[$];
  delay_result_t got_delay;
  delay_result_t want_delay;

  int  errors = 0;
  int  num_requests = 0;
  int  num_reseeds = 0;
  int  num_faults = 0;
  int  num_settings = 0;
  bit  quiet_in = 1'b0;

  reseeded_xorshift_random_delay u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_entropy_word      (in_entropy_word),
    .in_max_delay         (in_max_delay),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_delay_value      (out_delay_value),
    .out_reseeded         (out_reseeded),
    .out_zero_state_fault (out_zero_state_fault)
  );

  always #5 clk = ~clk;

  // reseed if due, step the counter, advance xorshift32, reduce by the bound
  function automatic delay_result_t advance_delay(input logic [DW-1:0] entropy,
                                                  input logic [DW-1:0] bound);
    delay_result_t r;
    logic [CW-1:0] span;
    logic [DW-1:0] x;
    span = (rng_interval == '0) ? CW'(1) : rng_interval;
    r.reseeded = (rng_count == '0) || (rng_state == '0);
    if (r.reseeded) rng_state = entropy;
    rng_count = rng_count + CW'(1);
    if (rng_count >= span) rng_count = '0;
    r.fault = (rng_state == '0);
    r.delay = '0;
    if (!r.fault) begin
      x = rng_state;
      x ^= x << rxd_pkg::SHIFT_A;
      x ^= x >> rxd_pkg::SHIFT_B;
      x ^= x << rxd_pkg::SHIFT_C;
      rng_state = x;
      if (bound != '0) r.delay = rng_state % bound;
    end
    return r;
  endfunction

  // present one request, hold it until the transfer
  task automatic send_request(input logic [DW-1:0] entropy,
                              input logic [DW-1:0] bound);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_entropy_word <= entropy;
    in_max_delay    <= bound;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic record_request(input delay_result_t r);
    pending_delays.push_back(r);
    num_requests++;
    if (r.reseeded) num_reseeds++;
    if (r.fault) num_faults++;
  endtask

  // drop valid, wait for every result, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_delays.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [CW-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    rng_interval = value;
    num_settings++;
  endtask

  // result side back-pressure
  initial begin
    int hold;
    int transfers;
    bit quiet_out;
    transfers = 0;
    quiet_out = 1'b0;
    forever begin
      hold = quiet_out ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid));
      transfers++;
      if (transfers % 40 == 0) quiet_out = ($urandom_range(0, 3) == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_delay = '{out_delay_value, out_reseeded, out_zero_state_fault};
      if (pending_delays.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got delay %0d reseeded %0b fault %0b",
                 $time, got_delay.delay, got_delay.reseeded, got_delay.fault);
      end else begin
        want_delay = pending_delays.pop_front();
        if (got_delay.delay !== want_delay.delay) begin
          errors++;
          $display("%0t: delay_value mismatch, expected %0d, got %0d",
                   $time, want_delay.delay, got_delay.delay);
        end
        if (got_delay.reseeded !== want_delay.reseeded) begin
          errors++;
          $display("%0t: reseeded mismatch, expected %0b, got %0b",
                   $time, want_delay.reseeded, got_delay.reseeded);
        end
        if (got_delay.fault !== want_delay.fault) begin
          errors++;
          $display("%0t: zero_state_fault mismatch, expected %0b, got %0b",
                   $time, want_delay.fault, got_delay.fault);
        end
      end
    end
  end

  initial begin
    request_row_t  rows [NUM_ROWS];
    logic [CW-1:0] phase_intervals [NUM_PHASES];
    delay_result_t r;
    logic [DW-1:0] entropy;
    logic [DW-1:0] bound;

    rows = '{
      // fault right after reset, then again while the state stays zero
      '{1'b0, 16'd0, 32'h0000_0000, 32'h0000_0005,   1'b1, '{32'd0, 1'b1, 1'b1}},
      '{1'b0, 16'd0, 32'h0000_0000, 32'hFFFF_FFFF,   1'b1, '{32'd0, 1'b1, 1'b1}},
      // reseed from one with a zero bound
      '{1'b0, 16'd0, 32'h0000_0001, 32'h0000_0000,   1'b1, '{32'd0, 1'b1, 1'b0}},
      '{1'b0, 16'd0, 32'hDEAD_BEEF, 32'h0000_0001,   1'b1, '{32'd0, 1'b0, 1'b0}},
      // zero entropy is ignored when no reseed is due
      '{1'b0, 16'd0, 32'h0000_0000, 32'hFFFF_FFFF,   1'b0, '0},
      '{1'b0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,   1'b0, '0},
      '{1'b0, 16'd0, 32'h1234_5678, 32'h8000_0000,   1'b0, '0},
      '{1'b0, 16'd0, 32'h0000_0000, 32'h0000_0002,   1'b0, '0},
      '{1'b0, 16'd0, 32'hFFFF_FFFF, 32'h0000_0007,   1'b0, '0},
      '{1'b0, 16'd0, 32'h8000_0000, 32'h0001_0000,   1'b0, '0},
      // interval of one: every request after the first reseeds
      '{1'b1, 16'd1, 32'hA5A5_A5A5, 32'd1000,        1'b0, '0},
      '{1'b0, 16'd0, 32'h0000_0000, 32'd1000,        1'b1, '{32'd0, 1'b1, 1'b1}},
      '{1'b0, 16'd0, 32'h0F0F_0F0F, 32'hFFFF_FFFF,   1'b0, '0},
      // interval of zero acts as one
      '{1'b1, 16'd0, 32'h8000_0000, 32'h0000_0003,   1'b0, '0},
      '{1'b0, 16'd0, 32'h0000_0000, 32'h0000_0003,   1'b1, '{32'd0, 1'b1, 1'b1}},
      '{1'b1, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'd0, 1'b1, 1'b0}},
      '{1'b0, 16'd0, 32'h0000_0001, 32'h0000_0010,   1'b0, '0},
      '{1'b0, 16'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,   1'b0, '0},
      '{1'b0, 16'd0, 32'h5555_5555, 32'hAAAA_AAAA,   1'b0, '0},
      // interval lowered below the running count
      '{1'b1, 16'd2, 32'h1234_5678, 32'd100,         1'b0, '0},
      '{1'b0, 16'd0, 32'hCAFE_F00D, 32'd100,         1'b0, '0},
      '{1'b0, 16'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE,   1'b0, '0}
    };
    phase_intervals = '{16'd1, 16'd3, 16'd7, 16'hFFFF, 16'd5,
                        16'd0, 16'd16, 16'd50, 16'd2, 16'd1000};

    rng_state    = '0;
    rng_count    = '0;
    rng_interval = rxd_pkg::RESEED_INTERVAL_RESET;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].set_interval) begin
        drain_results();
        write_interval(rows[i].interval);
      end
      send_request(rows[i].entropy, rows[i].bound);
      r = advance_delay(rows[i].entropy, rows[i].bound);
      record_request(rows[i].known ? rows[i].known_result : r);
    end

    foreach (phase_intervals[p]) begin
      drain_results();
      write_interval(phase_intervals[p]);
      for (int n = 0; n < PHASE_REQS; n++) begin
        if (n % 50 == 0) quiet_in = ($urandom_range(0, 3) == 0);
        // hold off once per phase until the result side is empty
        if (n == PHASE_REQS / 2) begin
          in_valid <= 1'b0;
          while (pending_delays.size() != 0) @(posedge clk);
        end
        case ($urandom_range(0, 9))
          0:       entropy = '0;
          1:       entropy = '1;
          2:       entropy = DW'(1) << $urandom_range(0, DW - 1);
          default: entropy = $urandom;
        endcase
        case ($urandom_range(0, 11))
          0:       bound = '0;
          1:       bound = DW'(1);
          2:       bound = $urandom_range(2, 16);
          3:       bound = '1;
          4:       bound = DW'(1) << $urandom_range(0, DW - 1);
          5:       bound = $urandom >> $urandom_range(0, DW - 1);
          default: bound = $urandom;
        endcase
        send_request(entropy, bound);
        r = advance_delay(entropy, bound);
        record_request(r);
      end
    end

    drain_results();
    $display("Ran %0d requests over %0d interval settings: %0d reseeds, %0d zero-state faults",
             num_requests, num_settings, num_reseeds, num_faults);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", pending_delays.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* reseeded_xorshift_random_delay.f */
design/rxd_pkg.sv
design/rxd_ctrl.sv
design/rxd_dp.sv
design/reseeded_xorshift_random_delay.sv
tb/tb_reseeded_xorshift_random_delay.sv
